// File: sv/spp_pkg.sv
// Shared types, constants and tables of the polyphonic sample player.
`default_nettype none
package spp_pkg;

  localparam int VOICES       = 16;
  localparam int SAMPLE_DEPTH = 65536;

  localparam int VIDX_W    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNT_W     = $clog2(VOICES + 1);
  localparam int SADDR_W   = $clog2(SAMPLE_DEPTH);
  localparam int FRAME_CAP = (SAMPLE_DEPTH < 65536) ? SAMPLE_DEPTH : 65536;
  localparam int ACC_W     = 34 + VIDX_W;

  localparam logic [16:0] FRAC_ONE  = 17'd65536;
  localparam logic [16:0] HUNDREDTH = 17'd655;

  localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
  localparam logic [1:0] CMD_NOTE_OFF = 2'd1;
  localparam logic [1:0] CMD_WRITE    = 2'd2;
  localparam logic [1:0] CMD_RENDER   = 2'd3;

  localparam logic [1:0] MODE_LOOP = 2'd1;
  localparam logic [1:0] MODE_GATE = 2'd2;

  localparam logic [2:0] REG_VOLUME     = 3'd0;
  localparam logic [2:0] REG_START      = 3'd1;
  localparam logic [2:0] REG_END        = 3'd2;
  localparam logic [2:0] REG_LOOP_START = 3'd3;
  localparam logic [2:0] REG_LOOP_END   = 3'd4;
  localparam logic [2:0] REG_PLAY_MODE  = 3'd5;
  localparam logic [2:0] REG_ROOT_PITCH = 3'd6;
  localparam logic [2:0] REG_FRAMES     = 3'd7;

  typedef struct packed {
    logic [15:0] volume;
    logic [15:0] start_frac;
    logic [16:0] end_frac;
    logic [15:0] loop_start_frac;
    logic [16:0] loop_end_frac;
    logic [1:0]  play_mode;
    logic [6:0]  root_pitch;
    logic [16:0] frame_count;
  } spp_cfg_t;

  typedef struct packed {
    logic [16:0] frames;
    logic [33:0] start_pos;
    logic [33:0] end_pos;
    logic [33:0] lstart;
    logic [33:0] lend;
    logic [32:0] limit;
  } spp_geo_t;

  typedef struct packed {
    logic [6:0]  pitch;
    logic [15:0] velocity;
    logic [33:0] position;
    logic [27:0] rate;
    logic [31:0] age;
  } voice_rec_t;

  typedef struct packed {
    logic               we;
    logic [SADDR_W-1:0] waddr;
    logic signed [15:0] wdata;
    logic               re;
    logic [SADDR_W-1:0] raddr;
  } smp_req_t;

  typedef struct packed {
    logic              we;
    logic [VIDX_W-1:0] waddr;
    voice_rec_t        wdata;
    logic              re;
    logic [VIDX_W-1:0] raddr;
  } voice_req_t;

  // 2^(n/12) in Q1.30
  function automatic logic [31:0] semitone_q30(input logic [3:0] n);
    logic [31:0] r;
    case (n)
      4'd0:    r = 32'd1073741824;
      4'd1:    r = 32'd1137589835;
      4'd2:    r = 32'd1205234447;
      4'd3:    r = 32'd1276901417;
      4'd4:    r = 32'd1352829926;
      4'd5:    r = 32'd1433273380;
      4'd6:    r = 32'd1518500250;
      4'd7:    r = 32'd1608794974;
      4'd8:    r = 32'd1704458901;
      4'd9:    r = 32'd1805811301;
      4'd10:   r = 32'd1913190429;
      4'd11:   r = 32'd2026954652;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/spp_cmd_if.sv
// Command channel: valid/ready handshake with the command word payload.
`default_nettype none
interface spp_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [6:0]         pitch;
  logic [15:0]        velocity;
  logic [15:0]        sample_address;
  logic signed [15:0] sample_value;

  modport source(output valid, command, pitch, velocity, sample_address, sample_value,
                 input ready);
  modport sink(input valid, command, pitch, velocity, sample_address, sample_value,
               output ready);
endinterface
`default_nettype wire

// File: sv/spp_res_if.sv
// Result channel: valid/ready handshake with the mixed sample word.
`default_nettype none
interface spp_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] audio_sample;
  logic               clipped;
  logic [4:0]         active_voices;

  modport source(output valid, audio_sample, clipped, active_voices, input ready);
  modport sink(input valid, audio_sample, clipped, active_voices, output ready);
endinterface
`default_nettype wire

// File: sv/polyphonic_sample_player.sv
// Polyphonic sample player top level: registers, sequencer and the two stores.
//
// The cmd channel takes one command word per handshake: note on, note off,
// sample write or render. Only a render produces a word on the result
// channel. Write the registers through the APB port only while the block
// idles; the block itself does not enforce this. A note on writes a free
// voice directly, else it first runs an age scan through the voice store;
// a note off scans the voice store until it finds the note. A render steps
// through every voice and takes each active one through a voice store read,
// two sample store reads and two multiply stages.
// The result sits in an output register: the next command is taken while it
// waits, and a further render holds at its end until the receiver takes it.
// Reset clears the registers to defaults and silences every voice; the
// sample store is not cleared and holds garbage until written.
`default_nettype none
module polyphonic_sample_player
  import spp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  spp_cmd_if.sink          cmd,
  spp_res_if.source        result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  spp_cfg_t           cfg;
  spp_geo_t           geo;
  smp_req_t           sreq;
  voice_req_t         vreq;
  logic signed [15:0] s_rdata;
  voice_rec_t         v_rdata;

  spp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .geo     (geo)
  );

  spp_sample_ram u_sample_ram (
    .clk   (clk),
    .req   (sreq),
    .rdata (s_rdata)
  );

  spp_voice_ram u_voice_ram (
    .clk   (clk),
    .req   (vreq),
    .rdata (v_rdata)
  );

  spp_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .geo     (geo),
    .cmd     (cmd),
    .result  (result),
    .sreq    (sreq),
    .s_rdata (s_rdata),
    .vreq    (vreq),
    .v_rdata (v_rdata)
  );

endmodule
`default_nettype wire

// File: sv/spp_sample_ram.sv
// Sample store: one write port, one registered read port.
`default_nettype none
module spp_sample_ram
  import spp_pkg::*;
(
  input  wire logic        clk,
  input  wire smp_req_t    req,
  output logic signed [15:0] rdata
);

  logic signed [15:0] mem [SAMPLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule
`default_nettype wire

// File: sv/spp_voice_ram.sv
// Voice record store: one write port, one registered read port.
`default_nettype none
module spp_voice_ram
  import spp_pkg::*;
(
  input  wire logic       clk,
  input  wire voice_req_t req,
  output voice_rec_t      rdata
);

  voice_rec_t mem [VOICES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule
`default_nettype wire

// File: sv/spp_regs.sv
// APB register file and derived playback geometry.
`default_nettype none
module spp_regs
  import spp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output spp_cfg_t         cfg,
  output spp_geo_t         geo
);

  logic [2:0]  idx;
  logic [16:0] frames;
  logic [16:0] end_fix;
  logic [16:0] lend_fix;

  function automatic logic [16:0] fix_end(input logic [15:0] lo, input logic [16:0] hi);
    logic [16:0] h;
    logic [16:0] s;
    h = (hi > FRAC_ONE) ? FRAC_ONE : hi;
    s = {1'b0, lo} + HUNDREDTH;
    if (h <= {1'b0, lo}) begin
      h = (s > FRAC_ONE) ? FRAC_ONE : s;
    end
    return h;
  endfunction

  assign pready = 1'b1;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.volume          <= 16'd55705;
      cfg.start_frac      <= 16'd0;
      cfg.end_frac        <= FRAC_ONE;
      cfg.loop_start_frac <= 16'd0;
      cfg.loop_end_frac   <= FRAC_ONE;
      cfg.play_mode       <= 2'd0;
      cfg.root_pitch      <= 7'd60;
      cfg.frame_count     <= 17'd0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_VOLUME:     cfg.volume          <= pwdata[15:0];
        REG_START:      cfg.start_frac      <= pwdata[15:0];
        REG_END:        cfg.end_frac        <= pwdata[16:0];
        REG_LOOP_START: cfg.loop_start_frac <= pwdata[15:0];
        REG_LOOP_END:   cfg.loop_end_frac   <= pwdata[16:0];
        REG_PLAY_MODE:  cfg.play_mode       <= pwdata[1:0];
        REG_ROOT_PITCH: cfg.root_pitch      <= pwdata[6:0];
        REG_FRAMES:     cfg.frame_count     <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_VOLUME:     prdata = 32'(cfg.volume);
      REG_START:      prdata = 32'(cfg.start_frac);
      REG_END:        prdata = 32'(cfg.end_frac);
      REG_LOOP_START: prdata = 32'(cfg.loop_start_frac);
      REG_LOOP_END:   prdata = 32'(cfg.loop_end_frac);
      REG_PLAY_MODE:  prdata = 32'(cfg.play_mode);
      REG_ROOT_PITCH: prdata = 32'(cfg.root_pitch);
      REG_FRAMES:     prdata = 32'(cfg.frame_count);
      default:        prdata = 32'd0;
    endcase
  end

  assign frames   = (cfg.frame_count > 17'(FRAME_CAP)) ? 17'(FRAME_CAP) : cfg.frame_count;
  assign end_fix  = fix_end(cfg.start_frac, cfg.end_frac);
  assign lend_fix = fix_end(cfg.loop_start_frac, cfg.loop_end_frac);

  // positions in Q16.16, derived straight from the registers
  always_comb begin
    geo.frames    = frames;
    geo.start_pos = 34'(cfg.start_frac * frames);
    geo.end_pos   = 34'(end_fix * frames);
    geo.lstart    = 34'(cfg.loop_start_frac * frames);
    geo.lend      = 34'(lend_fix * frames);
    geo.limit     = {frames, 16'd0};
  end

endmodule
`default_nettype wire

// File: sv/spp_engine.sv
// Command sequencer: voice allocation, note off and the per-voice render loop.
`default_nettype none
module spp_engine
  import spp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire spp_cfg_t    cfg,
  input  wire spp_geo_t    geo,
  spp_cmd_if.sink          cmd,
  spp_res_if.source        result,
  output smp_req_t         sreq,
  input  wire logic signed [15:0] s_rdata,
  output voice_req_t       vreq,
  input  wire voice_rec_t  v_rdata
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_ON_SCAN  = 10'b0000000010,
    S_ON_WRITE = 10'b0000000100,
    S_OFF_SCAN = 10'b0000001000,
    S_CHK      = 10'b0000010000,
    S_RA       = 10'b0000100000,
    S_RB       = 10'b0001000000,
    S_MUL      = 10'b0010000000,
    S_ACC      = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_t;

  state_t state;

  logic [VOICES-1:0]  active;
  logic [VOICES-1:0]  gated;
  logic [VIDX_W-1:0]  vidx;
  logic [VIDX_W-1:0]  vidx_inc;
  logic [VIDX_W-1:0]  pick;
  logic [VIDX_W-1:0]  free_idx;
  logic               any_free;
  logic               last;
  logic [31:0]        best_age;
  logic [31:0]        age_counter;
  logic [6:0]         lat_pitch;
  logic [15:0]        lat_vel;
  voice_rec_t         cur;
  logic [33:0]        pos_w;
  logic [15:0]        frac;
  logic [15:0]        jidx;
  logic signed [15:0] samp_a;
  logic [31:0]        vv;
  logic signed [32:0] val;
  logic signed [65:0] prod;
  logic signed [33:0] term;
  logic signed [ACC_W-1:0] acc;
  logic               res_valid;
  logic signed [15:0] res_sample;
  logic               res_clip;
  logic [4:0]         res_count;

  logic               accept;
  logic               no_frames;
  logic               over;
  logic               reload;
  logic               kill;
  logic [33:0]        pos1;
  logic [33:0]        pos2;
  logic [15:0]        fi;
  logic [16:0]        fi_inc;
  logic [16:0]        fmax;
  logic [15:0]        fj;
  logic               off_hit;
  logic [27:0]        new_rate;
  voice_rec_t         new_rec;
  voice_rec_t         upd_rec;
  logic signed [16:0] diff;
  logic signed [33:0] dprod;
  logic signed [33:0] val_sum;
  logic [ACC_W-32:0]  top_bits;
  logic               fits;
  logic [CNT_W-1:0]   cnt;

  function automatic logic [27:0] pitch_rate(input logic [6:0] p, input logic [6:0] r);
    logic [8:0]  u;
    logic [15:0] qm;
    logic [4:0]  q;
    logic [8:0]  rem9;
    logic [4:0]  sh;
    logic [32:0] sum;
    u    = {2'b0, p} + 9'd132 - {2'b0, r};
    qm   = 16'(u * 8'd171);
    q    = qm[15:11];
    rem9 = u - 9'({4'd0, q} * 9'd12);
    sh   = 5'd25 - q;
    sum  = {1'b0, semitone_q30(rem9[3:0])} + (33'd1 << (sh - 5'd1));
    return 28'(sum >> sh);
  endfunction

  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);
  assign no_frames = (geo.frames == 17'd0);
  assign vidx_inc  = vidx + VIDX_W'(1);
  assign last      = (vidx == VIDX_W'(VOICES - 1));

  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int v = VOICES - 1; v >= 0; v--) begin
      if (!active[v]) begin
        any_free = 1'b1;
        free_idx = VIDX_W'(v);
      end
    end
  end

  // voice check: end of play, loop wrap, frame pair
  assign over   = (v_rdata.position >= geo.end_pos) || (v_rdata.position >= {1'b0, geo.limit});
  assign reload = (cfg.play_mode == MODE_LOOP) || ((cfg.play_mode == MODE_GATE) && gated[vidx]);
  assign kill   = over && !reload;
  assign pos1   = over ? geo.lstart : v_rdata.position;
  assign pos2   = ((cfg.play_mode == MODE_LOOP) && (pos1 >= geo.lend)) ? geo.lstart : pos1;
  assign fi     = pos2[31:16];
  assign fi_inc = {1'b0, fi} + 17'd1;
  assign fmax   = geo.frames - 17'd1;
  assign fj     = (fi_inc < geo.frames) ? fi_inc[15:0] : fmax[15:0];

  assign off_hit = active[vidx] && (v_rdata.pitch == lat_pitch);

  assign new_rate         = pitch_rate(lat_pitch, cfg.root_pitch);
  assign new_rec.pitch    = lat_pitch;
  assign new_rec.velocity = lat_vel;
  assign new_rec.position = geo.start_pos;
  assign new_rec.rate     = new_rate;
  assign new_rec.age      = age_counter + 32'd1;

  always_comb begin
    upd_rec          = cur;
    upd_rec.position = pos_w + {6'd0, cur.rate};
  end

  assign diff    = {s_rdata[15], s_rdata} - {samp_a[15], samp_a};
  assign dprod   = diff * $signed({1'b0, frac});
  assign val_sum = $signed({samp_a[15], samp_a[15], samp_a, 16'd0}) + dprod;
  assign term    = prod[65:32];

  assign top_bits = acc[ACC_W-1:31];
  assign fits     = (&top_bits) || !(|top_bits);

  always_comb begin
    cnt = '0;
    for (int v = 0; v < VOICES; v++) begin
      cnt = cnt + CNT_W'(active[v]);
    end
  end

  // memory requests
  always_comb begin
    sreq       = '0;
    vreq       = '0;
    sreq.waddr = SADDR_W'(cmd.sample_address);
    sreq.wdata = cmd.sample_value;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd.command)
            CMD_WRITE:    sreq.we = (32'(cmd.sample_address) < SAMPLE_DEPTH);
            CMD_NOTE_ON:  vreq.re = !no_frames && !any_free;
            CMD_NOTE_OFF: vreq.re = !no_frames;
            CMD_RENDER:   vreq.re = !no_frames;
            default: ;
          endcase
        end
      end
      S_ON_SCAN: begin
        vreq.re    = !last;
        vreq.raddr = vidx_inc;
      end
      S_ON_WRITE: begin
        vreq.we    = 1'b1;
        vreq.waddr = pick;
        vreq.wdata = new_rec;
      end
      S_OFF_SCAN: begin
        vreq.re    = !off_hit && !last;
        vreq.raddr = vidx_inc;
      end
      S_CHK: begin
        if (!active[vidx] || kill) begin
          vreq.re    = !last;
          vreq.raddr = vidx_inc;
        end else begin
          sreq.re    = 1'b1;
          sreq.raddr = SADDR_W'(fi);
        end
      end
      S_RA: begin
        sreq.re    = 1'b1;
        sreq.raddr = SADDR_W'(jidx);
      end
      S_ACC: begin
        vreq.we    = 1'b1;
        vreq.waddr = vidx;
        vreq.wdata = upd_rec;
        vreq.re    = !last;
        vreq.raddr = vidx_inc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      active      <= '0;
      gated       <= '0;
      age_counter <= 32'd0;
      res_valid   <= 1'b0;
      vidx        <= '0;
    end else begin
      if (result.ready && (state != S_DONE)) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          vidx <= '0;
          acc  <= '0;
          if (accept) begin
            lat_pitch <= cmd.pitch;
            lat_vel   <= cmd.velocity;
            case (cmd.command)
              CMD_NOTE_ON: begin
                if (!no_frames) begin
                  pick  <= free_idx;
                  state <= any_free ? S_ON_WRITE : S_ON_SCAN;
                end
              end
              CMD_NOTE_OFF: begin
                if (!no_frames) begin
                  state <= S_OFF_SCAN;
                end
              end
              CMD_RENDER: begin
                state <= no_frames ? S_DONE : S_CHK;
              end
              default: ;
            endcase
          end
        end
        S_ON_SCAN: begin
          // oldest voice, lowest index on a tie
          if ((vidx == '0) || (v_rdata.age < best_age)) begin
            best_age <= v_rdata.age;
            pick     <= vidx;
          end
          vidx <= vidx_inc;
          if (last) begin
            state <= S_ON_WRITE;
          end
        end
        S_ON_WRITE: begin
          active[pick] <= 1'b1;
          gated[pick]  <= 1'b1;
          age_counter  <= age_counter + 32'd1;
          state        <= S_IDLE;
        end
        S_OFF_SCAN: begin
          vidx <= vidx_inc;
          if (off_hit) begin
            gated[vidx] <= 1'b0;
            if (cfg.play_mode == MODE_GATE) begin
              active[vidx] <= 1'b0;
            end
            state <= S_IDLE;
          end else if (last) begin
            state <= S_IDLE;
          end
        end
        S_CHK: begin
          cur   <= v_rdata;
          pos_w <= pos2;
          frac  <= pos2[15:0];
          jidx  <= fj;
          vv    <= v_rdata.velocity * cfg.volume;
          if (!active[vidx] || kill) begin
            if (active[vidx]) begin
              active[vidx] <= 1'b0;
            end
            vidx <= vidx_inc;
            if (last) begin
              state <= S_DONE;
            end
          end else begin
            state <= S_RA;
          end
        end
        S_RA: begin
          samp_a <= s_rdata;
          state  <= S_RB;
        end
        S_RB: begin
          val   <= val_sum[32:0];
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= val * $signed({1'b0, vv});
          state <= S_ACC;
        end
        S_ACC: begin
          acc  <= acc + ACC_W'(term);
          vidx <= vidx_inc;
          state <= last ? S_DONE : S_CHK;
        end
        S_DONE: begin
          // hold until the output word is free
          if (!res_valid || result.ready) begin
            res_valid  <= 1'b1;
            res_clip   <= !fits;
            res_sample <= fits ? acc[31:16] : (acc[ACC_W-1] ? 16'sh8000 : 16'sh7fff);
            res_count  <= 5'(cnt);
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid         = res_valid;
  assign result.audio_sample  = res_sample;
  assign result.clipped       = res_clip;
  assign result.active_voices = res_count;

endmodule
`default_nettype wire
